[rtl/core/bctl_pkg.sv]
// Shared types and constants of the block cache tag and LRU engine.
// No dependencies; imported by bctl_ctrl and block_cache_tag_lru_unit.
package bctl_pkg;

  localparam int OP_W    = 2;
  localparam int STORE_W = 4;
  localparam int SLOT_W  = 4;
  localparam int AGE_W   = 64;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP     = 2'd0,
    OP_INSTALL    = 2'd1,
    OP_INV_SECTOR = 2'd2,
    OP_INV_DEVICE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } result_t;

endpackage

[rtl/core/bctl_tag_ram.sv]
// Tag and age memory: one write port, one read port, registered read data.
// Standalone; used by block_cache_tag_lru_unit.
module bctl_tag_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 124,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/bctl_ctrl.sv]
// Request sequencer: scans the tag memory one entry per cycle, tracks match,
// first free slot and oldest entry, then writes back. Uses bctl_pkg.
module bctl_ctrl #(
  parameter int ENTRIES     = 16,
  parameter int SECTOR_BITS = 48,
  parameter int DEVICE_BITS = 8,
  parameter int IDX_W       = 4,
  parameter int WORD_W      = 124
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  bctl_pkg::op_t                 req_op,
  input  logic [bctl_pkg::STORE_W-1:0]  req_store,
  input  logic [DEVICE_BITS-1:0]        req_device,
  input  logic [SECTOR_BITS-1:0]        req_sector,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bctl_pkg::result_t             res,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output logic [WORD_W-1:0]             mem_wdata,
  output logic                          mem_re,
  output logic [IDX_W-1:0]              mem_raddr,
  input  logic [WORD_W-1:0]             mem_rdata
);

  import bctl_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int DEV_LSB = STORE_W;
  localparam int SEC_LSB = STORE_W + DEVICE_BITS;
  localparam int AGE_LSB = STORE_W + DEVICE_BITS + SECTOR_BITS;

  state_t                 state_r, state_nxt;
  op_t                    op_r;
  logic [STORE_W-1:0]     store_r;
  logic [DEVICE_BITS-1:0] dev_r;
  logic [SECTOR_BITS-1:0] sec_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   p_vld_r;
  logic [IDX_W-1:0]       p_idx_r;
  logic                   p_ent_vld_r;
  logic [ENTRIES-1:0]     valid_r;
  logic                   found_r;
  logic [IDX_W-1:0]       match_idx_r;
  logic                   inv_found_r;
  logic [IDX_W-1:0]       inv_idx_r;
  logic [IDX_W-1:0]       min_idx_r;
  logic [AGE_W-1:0]       min_age_r;
  logic [AGE_W-1:0]       clock_r;
  result_t                res_r;

  logic [STORE_W-1:0]     rd_store;
  logic [DEVICE_BITS-1:0] rd_dev;
  logic [SECTOR_BITS-1:0] rd_sec;
  logic [AGE_W-1:0]       rd_age;
  logic                   tag_eq;
  logic                   full_eq;
  logic                   hit_now;
  logic                   scan_last;
  logic                   issue;
  logic [AGE_W-1:0]       clock_inc;
  logic [IDX_W-1:0]       victim;
  logic [IDX_W-1:0]       res_idx;

  assign rd_store = mem_rdata[STORE_W-1:0];
  assign rd_dev   = mem_rdata[DEV_LSB +: DEVICE_BITS];
  assign rd_sec   = mem_rdata[SEC_LSB +: SECTOR_BITS];
  assign rd_age   = mem_rdata[AGE_LSB +: AGE_W];

  assign tag_eq  = (rd_store == store_r) && (rd_dev == dev_r);
  assign full_eq = tag_eq && (rd_sec == sec_r);
  assign hit_now = p_vld_r && p_ent_vld_r &&
                   ((op_r == OP_INV_DEVICE) ? tag_eq : full_eq);

  assign scan_last = (cnt_r == CNT_W'(ENTRIES));
  assign issue     = (state_r == ST_SCAN) && !scan_last;
  assign mem_re    = issue;
  assign mem_raddr = cnt_r[IDX_W-1:0];

  assign clock_inc = clock_r + AGE_W'(1);
  assign victim    = found_r ? match_idx_r : (inv_found_r ? inv_idx_r : min_idx_r);
  assign res_idx   = (op_r == OP_INSTALL) ? victim :
                     ((op_r == OP_INV_DEVICE) ? '0 : match_idx_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = match_idx_r;
    mem_wdata = {clock_inc, sec_r, dev_r, store_r};
    if (state_r == ST_WRITE) begin
      case (op_r)
        OP_LOOKUP: mem_we = found_r;
        OP_INSTALL: begin
          mem_we    = 1'b1;
          mem_waddr = victim;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (req_valid) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_last) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_RESP;
      ST_RESP:  if (res_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      clock_r <= '0;
      p_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (req_valid) begin
            op_r        <= req_op;
            store_r     <= req_store;
            dev_r       <= req_device;
            sec_r       <= req_sector;
            cnt_r       <= '0;
            p_vld_r     <= 1'b0;
            found_r     <= 1'b0;
            match_idx_r <= '0;
            inv_found_r <= 1'b0;
          end
        end
        ST_SCAN: begin
          p_vld_r     <= issue;
          p_idx_r     <= mem_raddr;
          p_ent_vld_r <= issue && valid_r[mem_raddr];
          if (issue) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
          if (hit_now) begin
            if (!found_r) begin
              match_idx_r <= p_idx_r;
            end
            found_r <= 1'b1;
            if (op_r == OP_INV_DEVICE) begin
              valid_r[p_idx_r] <= 1'b0;
            end
          end
          if (p_vld_r && !p_ent_vld_r && !inv_found_r) begin
            inv_found_r <= 1'b1;
            inv_idx_r   <= p_idx_r;
          end
          if (p_vld_r && p_ent_vld_r && ((p_idx_r == '0) || (rd_age < min_age_r))) begin
            min_idx_r <= p_idx_r;
            min_age_r <= rd_age;
          end
        end
        ST_WRITE: begin
          p_vld_r <= 1'b0;
          res_r.hit  <= found_r;
          res_r.slot <= SLOT_W'(res_idx);
          case (op_r)
            OP_LOOKUP: begin
              if (found_r) begin
                clock_r <= clock_inc;
              end
            end
            OP_INSTALL: begin
              valid_r[victim] <= 1'b1;
              clock_r         <= clock_inc;
            end
            OP_INV_SECTOR: begin
              if (found_r) begin
                valid_r[match_idx_r] <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        ST_RESP: ;
        default: ;
      endcase
    end
  end

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign res       = res_r;

endmodule

[rtl/core/block_cache_tag_lru_unit.sv]
// Top level of the block cache tag and LRU engine. A request is accepted in the
// idle state, then passes through a scan state that reads the tag memory once
// per entry and drains the read pipeline, a write-back state and a result state,
// which loads the result into the output register. A new request is accepted
// only once the result has left the result state and the block is idle again.
// A full output register stalls the result state. Synchronous active-low reset
// clears all valid bits and the use counter. Uses bctl_pkg, bctl_ctrl and bctl_tag_ram.
module block_cache_tag_lru_unit #(
  parameter int ENTRIES     = 16,
  parameter int SECTOR_BITS = 48,
  parameter int DEVICE_BITS = 8,
  localparam int IN_W  = ((bctl_pkg::OP_W + bctl_pkg::STORE_W + DEVICE_BITS
                           + SECTOR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((1 + bctl_pkg::SLOT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // operation, store_id, device_number, sector_number, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // hit, slot, zero pad
  output logic [OUT_W-1:0] out_tdata
);

  import bctl_pkg::*;

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORD_W  = STORE_W + DEVICE_BITS + SECTOR_BITS + AGE_W;
  localparam int ST_LSB  = OP_W;
  localparam int DEV_LSB = OP_W + STORE_W;
  localparam int SEC_LSB = OP_W + STORE_W + DEVICE_BITS;

  op_t                    req_op;
  logic [STORE_W-1:0]     req_store;
  logic [DEVICE_BITS-1:0] req_device;
  logic [SECTOR_BITS-1:0] req_sector;
  logic                   res_valid;
  logic                   res_ready;
  result_t                res;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [WORD_W-1:0]      mem_wdata;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_raddr;
  logic [WORD_W-1:0]      mem_rdata;
  logic                   out_tvalid_r;
  logic [OUT_W-1:0]       out_tdata_r;

  assign req_op     = op_t'(in_tdata[OP_W-1:0]);
  assign req_store  = in_tdata[ST_LSB +: STORE_W];
  assign req_device = in_tdata[DEV_LSB +: DEVICE_BITS];
  assign req_sector = in_tdata[SEC_LSB +: SECTOR_BITS];

  bctl_ctrl #(
    .ENTRIES     (ENTRIES),
    .SECTOR_BITS (SECTOR_BITS),
    .DEVICE_BITS (DEVICE_BITS),
    .IDX_W       (IDX_W),
    .WORD_W      (WORD_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_op     (req_op),
    .req_store  (req_store),
    .req_device (req_device),
    .req_sector (req_sector),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  bctl_tag_ram #(
    .DEPTH  (ENTRIES),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
      out_tdata_r  <= OUT_W'({res.slot, res.hit});
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
